FILE: rtl/core/chained_hash_dictionary_core_macros.svh
// assertion helpers shared by the rtl
`ifndef CHAINED_HASH_DICTIONARY_CORE_MACROS_SVH
`define CHAINED_HASH_DICTIONARY_CORE_MACROS_SVH

// checked only outside reset
`define CHD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define CHD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/core/chd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chd_pkg
// Shared sizes, codes and types of the chained hash dictionary.
// ----------------------------------------------------------------------------
package chd_pkg;

  localparam int TABLE_ENTRIES = 4096;
  localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
  localparam int STEP_W        = ADDR_W + 1;
  localparam int HASH_BUCKETS  = 3001;
  localparam int HASH_MULT     = 37;
  localparam int KEY_CHARS     = 32;
  localparam int KEY_WORDS     = 4;
  localparam int KEY_W         = 64 * KEY_WORDS;
  localparam int KADDR_W       = ADDR_W + $clog2(KEY_WORDS);
  localparam int PROBE_W       = 13;

  // reduction mod HASH_BUCKETS by reciprocal multiply, quotient estimate is
  // low by at most one
  localparam int MOD_SHIFT = 31 + $clog2(HASH_BUCKETS);
  localparam int QUO_W     = 64 - MOD_SHIFT;
  localparam logic [31:0] MOD_RECIP = 32'((64'd1 << MOD_SHIFT) / 64'(HASH_BUCKETS));

  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_FOUND     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam logic OP_INSERT = 1'b0;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] link;
  } vm_entry_t;

endpackage

FILE: rtl/core/chd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chd_ram
// Simple dual-port ram: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module chd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/chained_hash_dictionary_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_dictionary_core
// String dictionary in a chained hash table: insert and look up keys.
// ----------------------------------------------------------------------------
// After reset the block sweeps the entry ram, one entry a cycle, with
// in_stall_o high. Each word then goes through hashing (one character a
// cycle), reduction mod 3001 (a reciprocal multiply, a multiply and subtract,
// a final correction) and the table access: an insert into an empty home
// writes its key words there; a lookup does 1 to 4 key-word compares for
// each probe; an insert into a taken home scans down for a free entry and
// walks the chain links to the tail, then writes the link and the key words.
// Memory ports set the walk speed: one entry ram read and one key ram word a
// cycle. One word is in flight at a time; the result register lets the next
// word enter while a result waits.
module chained_hash_dictionary_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [63:0] key_chars_0_i,
  input  logic [63:0] key_chars_1_i,
  input  logic [63:0] key_chars_2_i,
  input  logic [63:0] key_chars_3_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [12:0] probes_o
);

  `include "chained_hash_dictionary_core_macros.svh"

  typedef enum logic [14:0] {
    S_CLEAR    = 15'b000000000000001,
    S_IDLE     = 15'b000000000000010,
    S_HASH     = 15'b000000000000100,
    S_MOD      = 15'b000000000001000,
    S_V_RD     = 15'b000000000010000,
    S_HOME_CHK = 15'b000000000100000,
    S_FREE_RD  = 15'b000000001000000,
    S_FREE_CHK = 15'b000000010000000,
    S_TAIL_RD  = 15'b000000100000000,
    S_TAIL_CHK = 15'b000001000000000,
    S_LINK_WR  = 15'b000010000000000,
    S_KEY_WR   = 15'b000100000000000,
    S_LK_VCHK  = 15'b001000000000000,
    S_LK_CMP   = 15'b010000000000000,
    S_OUT      = 15'b100000000000000
  } state_e;

  localparam logic [chd_pkg::ADDR_W-1:0] FREE_TOP = chd_pkg::ADDR_W'(chd_pkg::TABLE_ENTRIES - 1);
  localparam logic [chd_pkg::STEP_W-1:0] STEP_LIM = chd_pkg::STEP_W'(chd_pkg::TABLE_ENTRIES);

  state_e                             state_q, state_d;
  logic [chd_pkg::KEY_W-1:0]          raw_q, raw_d;
  logic [0:chd_pkg::KEY_WORDS-1][63:0] key_q, key_d;
  logic [4:0]                         pos_q, pos_d;
  logic                               ended_q, ended_d;
  logic [31:0]                        hash_q, hash_d;
  logic [63:0]                        prod_q, prod_d;
  logic [1:0]                         mcnt_q, mcnt_d;
  logic                               op_q, op_d;
  logic [chd_pkg::ADDR_W-1:0]         idx_q, idx_d;
  logic [chd_pkg::ADDR_W-1:0]         free_q, free_d;
  logic [chd_pkg::ADDR_W-1:0]         link_q, link_d;
  logic [chd_pkg::ADDR_W-1:0]         clr_q, clr_d;
  logic [chd_pkg::STEP_W-1:0]         steps_q, steps_d;
  logic [chd_pkg::PROBE_W-1:0]        probes_q, probes_d;
  logic [1:0]                         w_q, w_d;
  logic [1:0]                         res_q, res_d;
  logic                               out_valid_q, out_valid_d;
  logic [1:0]                         status_q, status_d;
  logic [chd_pkg::PROBE_W-1:0]        oprobes_q, oprobes_d;

  logic                               vm_we;
  logic [chd_pkg::ADDR_W-1:0]         vm_waddr, vm_raddr;
  chd_pkg::vm_entry_t                 vm_wdata, vm_rdata;
  logic                               km_we;
  logic [chd_pkg::KADDR_W-1:0]        km_waddr, km_raddr;
  logic [63:0]                        km_wdata, km_rdata;

  chd_ram #(
    .WIDTH($bits(chd_pkg::vm_entry_t)),
    .DEPTH(chd_pkg::TABLE_ENTRIES)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (vm_we),
    .waddr_i(vm_waddr),
    .wdata_i(vm_wdata),
    .raddr_i(vm_raddr),
    .rdata_o(vm_rdata)
  );

  chd_ram #(
    .WIDTH(64),
    .DEPTH(chd_pkg::TABLE_ENTRIES * chd_pkg::KEY_WORDS)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (km_we),
    .waddr_i(km_waddr),
    .wdata_i(km_wdata),
    .raddr_i(km_raddr),
    .rdata_o(km_rdata)
  );

  always_comb begin
    logic [7:0]  c;
    logic [31:0] rem_n;
    logic [63:0] kw;
    state_d     = state_q;
    raw_d       = raw_q;
    key_d       = key_q;
    pos_d       = pos_q;
    ended_d     = ended_q;
    hash_d      = hash_q;
    prod_d      = prod_q;
    mcnt_d      = mcnt_q;
    op_d        = op_q;
    idx_d       = idx_q;
    free_d      = free_q;
    link_d      = link_q;
    clr_d       = clr_q;
    steps_d     = steps_q;
    probes_d    = probes_q;
    w_d         = w_q;
    res_d       = res_q;
    status_d    = status_q;
    oprobes_d   = oprobes_q;
    out_valid_d = out_valid_q && out_stall_i;
    vm_we       = 1'b0;
    vm_waddr    = idx_q;
    vm_wdata    = '0;
    vm_raddr    = idx_q;
    km_we       = 1'b0;
    km_waddr    = {idx_q, w_q};
    km_wdata    = key_q[w_q];
    km_raddr    = {idx_q, w_q};
    c           = raw_q[chd_pkg::KEY_W-1 -: 8];
    rem_n       = (hash_q >= 32'(chd_pkg::HASH_BUCKETS)) ?
                  hash_q - 32'(chd_pkg::HASH_BUCKETS) : hash_q;
    kw          = key_q[w_q];

    case (state_q)
      S_CLEAR: begin
        vm_we    = 1'b1;
        vm_waddr = clr_q;
        clr_d    = clr_q + 1'b1;
        if (clr_q == FREE_TOP) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          raw_d   = {key_chars_0_i, key_chars_1_i, key_chars_2_i, key_chars_3_i};
          key_d   = '0;
          pos_d   = '0;
          ended_d = 1'b0;
          hash_d  = '0;
          op_d    = op_i;
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        // bytes after the first zero, or past the key length, read as zero
        if (ended_q || ({1'b0, pos_q} >= 6'(chd_pkg::KEY_CHARS)) || (c == 8'h00)) begin
          ended_d = 1'b1;
          key_d   = {key_q[0][55:0], key_q[1:chd_pkg::KEY_WORDS-1], 8'h00};
        end else begin
          hash_d = 32'(hash_q * 32'(chd_pkg::HASH_MULT) + {24'h0, c});
          key_d  = {key_q[0][55:0], key_q[1:chd_pkg::KEY_WORDS-1], c};
        end
        raw_d = {raw_q[chd_pkg::KEY_W-9:0], 8'h00};
        pos_d = pos_q + 1'b1;
        if (pos_q == 5'd31) begin
          mcnt_d  = 2'd2;
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        mcnt_d = mcnt_q - 1'b1;
        case (mcnt_q)
          2'd2: begin
            prod_d = 64'(hash_q) * 64'(chd_pkg::MOD_RECIP);
          end
          2'd1: begin
            hash_d = hash_q - 32'(64'(prod_q[63 -: chd_pkg::QUO_W]) *
                                  64'(chd_pkg::HASH_BUCKETS));
          end
          default: begin
            idx_d    = rem_n[chd_pkg::ADDR_W-1:0];
            steps_d  = '0;
            probes_d = '0;
            state_d  = S_V_RD;
          end
        endcase
      end
      S_V_RD: begin
        state_d = (op_q == chd_pkg::OP_INSERT) ? S_HOME_CHK : S_LK_VCHK;
      end
      S_HOME_CHK: begin
        w_d = '0;
        state_d = vm_rdata.valid ? S_FREE_RD : S_KEY_WR;
      end
      S_FREE_RD: begin
        vm_raddr = free_q;
        state_d  = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        if (!vm_rdata.valid) begin
          steps_d = '0;
          state_d = S_TAIL_RD;
        end else if (free_q == chd_pkg::ADDR_W'(1)) begin
          res_d   = chd_pkg::ST_FULL;
          state_d = S_OUT;
        end else begin
          free_d  = free_q - 1'b1;
          state_d = S_FREE_RD;
        end
      end
      S_TAIL_RD: begin
        state_d = S_TAIL_CHK;
      end
      S_TAIL_CHK: begin
        if ((vm_rdata.link != '0) && (steps_q < STEP_LIM)) begin
          idx_d   = vm_rdata.link;
          steps_d = steps_q + 1'b1;
          state_d = S_TAIL_RD;
        end else begin
          state_d = S_LINK_WR;
        end
      end
      S_LINK_WR: begin
        vm_we    = 1'b1;
        vm_wdata = '{valid: 1'b1, link: free_q};
        idx_d    = free_q;
        w_d      = '0;
        state_d  = S_KEY_WR;
      end
      S_KEY_WR: begin
        km_we = 1'b1;
        if (w_q == 2'd0) begin
          vm_we    = 1'b1;
          vm_wdata = '{valid: 1'b1, link: '0};
        end
        w_d = w_q + 1'b1;
        if (w_q == 2'(chd_pkg::KEY_WORDS - 1)) begin
          res_d   = chd_pkg::ST_INSERTED;
          state_d = S_OUT;
        end
      end
      S_LK_VCHK: begin
        if (!vm_rdata.valid || (steps_q == STEP_LIM)) begin
          res_d   = chd_pkg::ST_NOT_FOUND;
          state_d = S_OUT;
        end else begin
          steps_d  = steps_q + 1'b1;
          probes_d = (probes_q == '1) ? probes_q : probes_q + 1'b1;
          link_d   = vm_rdata.link;
          w_d      = '0;
          km_raddr = {idx_q, 2'd0};
          state_d  = S_LK_CMP;
        end
      end
      S_LK_CMP: begin
        if (kw < km_rdata) begin
          res_d   = chd_pkg::ST_NOT_FOUND;
          state_d = S_OUT;
        end else if (kw > km_rdata) begin
          idx_d = link_q;
          if (link_q == '0) begin
            res_d   = chd_pkg::ST_NOT_FOUND;
            state_d = S_OUT;
          end else begin
            state_d = S_V_RD;
          end
        end else if (w_q == 2'(chd_pkg::KEY_WORDS - 1)) begin
          res_d   = chd_pkg::ST_FOUND;
          state_d = S_OUT;
        end else begin
          w_d      = w_q + 1'b1;
          km_raddr = {idx_q, w_q + 1'b1};
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          status_d    = res_q;
          oprobes_d   = probes_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      free_q      <= FREE_TOP;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q     <= raw_d;
    key_q     <= key_d;
    pos_q     <= pos_d;
    ended_q   <= ended_d;
    hash_q    <= hash_d;
    prod_q    <= prod_d;
    mcnt_q    <= mcnt_d;
    op_q      <= op_d;
    idx_q     <= idx_d;
    link_q    <= link_d;
    steps_q   <= steps_d;
    probes_q  <= probes_d;
    w_q       <= w_d;
    res_q     <= res_d;
    status_q  <= status_d;
    oprobes_q <= oprobes_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign probes_o    = oprobes_q;

  `CHD_ASSERT(a_accept_starts_hash, in_valid_i && !in_stall_o |=> state_q == S_HASH,
              "accepted word did not start hashing")
  `CHD_ASSERT(a_result_held,
              state_q == S_OUT && out_valid_o && out_stall_i |=> $stable(status_o) && out_valid_o,
              "pending result overwritten")
  `CHD_ASSERT(a_entry_write_state, vm_we |-> state_q == S_CLEAR || state_q == S_LINK_WR || state_q == S_KEY_WR,
              "entry ram written outside a write state")
  `CHD_ASSERT(a_key_write_state, km_we |-> state_q == S_KEY_WR && state_q != S_IDLE,
              "key ram written outside key write")
  `CHD_ASSERT(a_free_nonzero, free_q != '0,
              "free scan pointer reached entry zero")

endmodule
